// ===== rtl/core/tasu_pkg.sv =====
`timescale 1ns / 1ps

package tasu_pkg;

    // table size and derived widths
    localparam int DEPTH     = 64;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int TICK_W    = 32;
    localparam int UNIT_W    = 8;
    localparam int TYPE_W    = 8;
    localparam int MAG_W     = 32;
    localparam int PENDING_W = 7;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_APPLY  = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NONE_DUE = 2'd2
    } t_status;

    // control states
    typedef enum logic {
        S_IDLE,
        S_OFF
    } t_state;

    // one table entry
    typedef struct packed {
        logic [TICK_W-1:0]       tick;
        logic [UNIT_W-1:0]       unit_id;
        logic [TYPE_W-1:0]       action_type;
        logic signed [MAG_W-1:0] magnitude;
    } t_entry;

    // what a cell hands to its right neighbor
    typedef struct packed {
        logic   lt;
        t_entry ent;
    } t_link;

    // command broadcast to every cell
    typedef struct packed {
        logic              insert;
        t_entry            ent;
        logic [TICK_W-1:0] ref_tick;
    } t_cell_cmd;

    // input beat
    typedef struct packed {
        logic [1:0]              operation;
        logic [UNIT_W-1:0]       unit_id;
        logic [TICK_W-1:0]       on_time;
        logic [TICK_W-1:0]       off_time;
        logic                    has_off;
        logic [TYPE_W-1:0]       action_type;
        logic signed [MAG_W-1:0] action_magnitude;
        logic [TICK_W-1:0]       ref_time;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic                    fired;
        logic [UNIT_W-1:0]       fired_unit;
        logic [TYPE_W-1:0]       fired_type;
        logic signed [MAG_W-1:0] fired_magnitude;
        logic [1:0]              status;
        logic [PENDING_W-1:0]    pending_count;
    } t_out_beat;

endpackage

// ===== rtl/core/tasu_if.sv =====
`timescale 1ns / 1ps

// command channel
interface tasu_in_if;
    logic               valid;
    logic               ready;
    tasu_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface tasu_out_if;
    logic                valid;
    logic                ready;
    tasu_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tasu_cell.sv =====
`timescale 1ns / 1ps

module tasu_cell (
    input  logic                i_clk,
    input  tasu_pkg::t_cell_cmd i_cmd,
    input  logic                i_valid,
    input  logic                i_sel,
    input  tasu_pkg::t_link     i_left,
    output tasu_pkg::t_link     o_link,
    output logic                o_keep,
    output tasu_pkg::t_entry    o_rd
);
    import tasu_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    // strictly earlier than the new entry: stays in place
    assign o_link.lt  = i_valid && (r_ent.tick < i_cmd.ent.tick);
    assign o_link.ent = r_ent;

    // not later than the reference time (kept by delete, due for apply)
    assign o_keep = i_valid && (r_ent.tick <= i_cmd.ref_tick);
    assign o_rd   = (i_sel && o_keep) ? r_ent : '0;

    // insert: first non-earlier cell takes the new entry, the rest shift right
    always_comb begin
        n_ent = r_ent;
        if (i_cmd.insert && !o_link.lt) begin
            n_ent = i_left.lt ? i_cmd.ent : i_left.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

// ===== rtl/core/tasu_chain.sv =====
`timescale 1ns / 1ps

module tasu_chain (
    input  logic                          i_clk,
    input  tasu_pkg::t_cell_cmd           i_cmd,
    input  logic [tasu_pkg::CNT_W-1:0]    i_count,
    input  logic [tasu_pkg::CNT_W-1:0]    i_rd_idx,
    output logic [tasu_pkg::CNT_W-1:0]    o_keep_cnt,
    output logic                          o_hit,
    output tasu_pkg::t_entry              o_hit_ent
);
    import tasu_pkg::*;

    localparam int ENT_W = $bits(t_entry);

    t_link            links [DEPTH];
    t_entry           rd    [DEPTH];
    logic [DEPTH:0]   keep;
    logic [DEPTH-1:0] due;
    logic [ENT_W-1:0] acc_ent;
    logic [CNT_W-1:0] acc_cnt;
    logic             acc_hit;

    // left boundary: everything is "after" it
    t_link head;
    assign head.lt  = 1'b1;
    assign head.ent = i_cmd.ent;

    assign keep[DEPTH] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic  valid;
        logic  sel;
        t_link left;

        assign valid = CNT_W'(g) < i_count;
        assign sel   = CNT_W'(g) == i_rd_idx;

        if (g == 0) begin : g_head
            assign left = head;
        end else begin : g_body
            assign left = links[g-1];
        end

        tasu_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_valid (valid),
            .i_sel   (sel),
            .i_left  (left),
            .o_link  (links[g]),
            .o_keep  (keep[g]),
            .o_rd    (rd[g])
        );

        assign due[g] = rd[g] != '0 || (sel && keep[g]);
    end

    // kept entries form a prefix; encode its edge into a count
    // the selected due cell is the only non-zero read; OR them together
    always_comb begin
        acc_cnt = '0;
        acc_ent = '0;
        acc_hit = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (keep[k] && !keep[k+1]) begin
                acc_cnt = acc_cnt | CNT_W'(k + 1);
            end
            acc_ent = acc_ent | rd[k];
            acc_hit = acc_hit | due[k];
        end
    end

    assign o_keep_cnt = acc_cnt;
    assign o_hit      = acc_hit;
    assign o_hit_ent  = t_entry'(acc_ent);

endmodule

// ===== rtl/core/timed_action_schedule_unit.sv =====
`timescale 1ns / 1ps

// channel  dir  beat        handshake
// i_in     in   t_in_beat   valid/ready
// o_out    out  t_out_beat  valid/ready
//
// One beat in, one beat out. Only an add with an off time goes through S_OFF
// for its second insert, one insert per cycle through the cell row.
// All compares and shifts happen in every cell at once; apply reads the cell
// at the read index through an OR reduction over the row.
// A new beat is taken when the control is idle and the result register is
// empty or draining. Reset (i_rst_n low, synchronous) empties the table.
module timed_action_schedule_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tasu_in_if.sink    i_in,
    tasu_out_if.source o_out
);
    import tasu_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    t_entry           r_off, n_off;
    t_out_beat        r_out, n_out;
    logic             r_out_vld, n_out_vld;

    t_cell_cmd        cmd;
    logic [CNT_W-1:0] keep_cnt;
    logic             hit;
    t_entry           hit_ent;
    logic             in_acc;
    logic             out_fire;

    // no beat is taken while reset is held
    assign i_in.ready = i_rst_n && (r_state == S_IDLE) && (!r_out_vld || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_fire   = r_out_vld && o_out.ready;

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    tasu_chain u_chain (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_count    (r_count),
        .i_rd_idx   (r_rd_idx),
        .o_keep_cnt (keep_cnt),
        .o_hit      (hit),
        .o_hit_ent  (hit_ent)
    );

    // next state, cell command and result
    always_comb begin
        logic [CNT_W:0] need_sum;
        t_out_beat      res;

        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_out     = r_out;
        n_out_vld = r_out_vld && !out_fire;

        n_off.tick        = i_in.data.off_time;
        n_off.unit_id     = i_in.data.unit_id;
        n_off.action_type = i_in.data.action_type;
        n_off.magnitude   = '0;

        cmd.insert              = 1'b0;
        cmd.ent.tick            = i_in.data.on_time;
        cmd.ent.unit_id         = i_in.data.unit_id;
        cmd.ent.action_type     = i_in.data.action_type;
        cmd.ent.magnitude       = i_in.data.action_magnitude;
        cmd.ref_tick            = i_in.data.ref_time;

        need_sum = {1'b0, r_count} + (i_in.data.has_off ? (CNT_W+1)'(2) : (CNT_W+1)'(1));

        res               = '0;
        res.status        = STATUS_DONE;
        res.pending_count = PENDING_W'(r_count);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_in.data.operation))
                        OP_ADD: begin
                            if (need_sum > (CNT_W+1)'(DEPTH)) begin
                                res.status = STATUS_FULL;
                                n_out      = res;
                                n_out_vld  = 1'b1;
                            end else begin
                                cmd.insert = 1'b1;
                                n_count    = r_count + CNT_W'(1);
                                if (i_in.data.has_off) begin
                                    n_state = S_OFF;
                                end else begin
                                    res.pending_count = PENDING_W'(n_count);
                                    n_out             = res;
                                    n_out_vld         = 1'b1;
                                end
                            end
                        end
                        OP_DELETE: begin
                            n_count           = keep_cnt;
                            res.pending_count = PENDING_W'(keep_cnt);
                            n_out             = res;
                            n_out_vld         = 1'b1;
                        end
                        OP_APPLY: begin
                            if (hit) begin
                                res.fired           = 1'b1;
                                res.fired_unit      = hit_ent.unit_id;
                                res.fired_type      = hit_ent.action_type;
                                res.fired_magnitude = hit_ent.magnitude;
                                n_rd_idx            = r_rd_idx + CNT_W'(1);
                            end else begin
                                res.status = STATUS_NONE_DUE;
                            end
                            n_out     = res;
                            n_out_vld = 1'b1;
                        end
                        default: begin
                            n_out     = res;
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_OFF: begin
                // second insert: the off-action
                cmd.insert        = 1'b1;
                cmd.ent           = r_off;
                n_count           = r_count + CNT_W'(1);
                res.pending_count = PENDING_W'(n_count);
                n_out             = res;
                n_out_vld         = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_off <= n_off;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_rd_idx_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= CNT_W'(DEPTH))
        else $error("read index beyond table depth");

    a_off_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OFF |-> r_count < CNT_W'(DEPTH))
        else $error("no room left for off-action insert");

    a_off_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OFF |=> r_out_vld && r_state == S_IDLE)
        else $error("add with off time did not produce its result");
`endif

endmodule
